@@ rtl/core/sfr_pkg.sv @@
// shared types and constants for the streaming find-and-replace block
package sfr_pkg;

    localparam int MAX_PATTERN_DEF = 8;
    localparam int BYTE_W          = 8;
    localparam int WORD_W          = 64;
    localparam int LEN_W           = 4;
    localparam int CFG_IDX_W       = 4;
    localparam int REPL_MAX        = 8;
    localparam int REPL_IDX_W      = 3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES      = 4'd0,
        CFG_PATTERN_LENGTH     = 4'd1,
        CFG_REPLACEMENT_BYTES  = 4'd2,
        CFG_REPLACEMENT_LENGTH = 4'd3
    } t_cfg_idx;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPEND,
        ST_CHECK,
        ST_REPL,
        ST_FLUSH,
        ST_FIN
    } t_state;

    // datapath operations
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_PASS,
        OP_APPEND,
        OP_RELEASE,
        OP_MATCH,
        OP_REPL,
        OP_FINISH
    } t_op;

    typedef struct packed {
        t_op  op;
        logic idle;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic bypass;
        logic prefix;
        logic full;
        logic repl_empty;
        logic repl_last;
        logic fill_zero;
        logic can_push;
        logic finish_ok;
    } t_status;

endpackage

@@ rtl/core/sfr_ctrl.sv @@
// sequencing controller for the find-and-replace datapath
module sfr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_cfg_valid,
    input  sfr_pkg::t_status i_status,
    output sfr_pkg::t_cmd    o_cmd
);

    sfr_pkg::t_state r_state;
    sfr_pkg::t_state n_state;
    sfr_pkg::t_state after_match;

    // state after the window has settled: flush on the last item
    assign after_match = i_status.last ? sfr_pkg::ST_FLUSH : sfr_pkg::ST_FIN;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sfr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sfr_pkg::ST_IDLE: begin
                if (!i_cfg_valid && i_in_valid) begin
                    n_state = sfr_pkg::ST_APPEND;
                end
            end
            sfr_pkg::ST_APPEND: begin
                if (!i_status.bypass) begin
                    n_state = sfr_pkg::ST_CHECK;
                end else if (i_status.can_push) begin
                    n_state = sfr_pkg::ST_FIN;
                end
            end
            sfr_pkg::ST_CHECK: begin
                if (i_status.prefix) begin
                    if (i_status.full && !i_status.repl_empty) begin
                        n_state = sfr_pkg::ST_REPL;
                    end else begin
                        n_state = after_match;
                    end
                end
            end
            sfr_pkg::ST_REPL: begin
                if (i_status.can_push && i_status.repl_last) begin
                    n_state = after_match;
                end
            end
            sfr_pkg::ST_FLUSH: begin
                if (i_status.fill_zero) begin
                    n_state = sfr_pkg::ST_FIN;
                end
            end
            sfr_pkg::ST_FIN: begin
                if (i_status.finish_ok) begin
                    n_state = sfr_pkg::ST_IDLE;
                end
            end
            default: n_state = sfr_pkg::ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd.op   = sfr_pkg::OP_NONE;
        o_cmd.idle = 1'b0;
        case (r_state)
            sfr_pkg::ST_IDLE: begin
                o_cmd.idle = 1'b1;
                if (!i_cfg_valid && i_in_valid) begin
                    o_cmd.op = sfr_pkg::OP_LOAD;
                end
            end
            sfr_pkg::ST_APPEND: begin
                if (!i_status.bypass) begin
                    o_cmd.op = sfr_pkg::OP_APPEND;
                end else if (i_status.can_push) begin
                    o_cmd.op = sfr_pkg::OP_PASS;
                end
            end
            sfr_pkg::ST_CHECK: begin
                if (i_status.prefix) begin
                    if (i_status.full) begin
                        o_cmd.op = sfr_pkg::OP_MATCH;
                    end
                end else if (i_status.can_push) begin
                    o_cmd.op = sfr_pkg::OP_RELEASE;
                end
            end
            sfr_pkg::ST_REPL: begin
                if (i_status.can_push) begin
                    o_cmd.op = sfr_pkg::OP_REPL;
                end
            end
            sfr_pkg::ST_FLUSH: begin
                if (!i_status.fill_zero && i_status.can_push) begin
                    o_cmd.op = sfr_pkg::OP_RELEASE;
                end
            end
            sfr_pkg::ST_FIN: begin
                if (i_status.finish_ok) begin
                    o_cmd.op = sfr_pkg::OP_FINISH;
                end
            end
            default: o_cmd.op = sfr_pkg::OP_NONE;
        endcase
    end

endmodule

@@ rtl/core/sfr_datapath.sv @@
// match window, configuration registers and output staging
module sfr_datapath #(
    parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  sfr_pkg::t_cmd                  i_cmd,
    output sfr_pkg::t_status               o_status,
    input  logic [sfr_pkg::BYTE_W-1:0]     i_text_byte,
    input  logic                           i_text_end,
    input  logic                           i_cfg_valid,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sfr_pkg::WORD_W-1:0]     i_cfg_data,
    input  logic                           i_out_stall,
    output logic                           o_out_valid,
    output logic [sfr_pkg::BYTE_W-1:0]     o_out_byte,
    output logic                           o_byte_present,
    output logic                           o_out_end
);

    localparam int BW = sfr_pkg::BYTE_W;
    localparam int LW = sfr_pkg::LEN_W;
    localparam int RW = sfr_pkg::REPL_IDX_W;

    logic [sfr_pkg::WORD_W-1:0]     r_pat_bytes;
    logic [LW-1:0]                  r_pat_len;
    logic [sfr_pkg::WORD_W-1:0]     r_rep_bytes;
    logic [LW-1:0]                  r_rep_len;
    logic [BW-1:0]                  r_in_byte;
    logic                           r_last;
    logic [BW-1:0]                  r_win [MAX_PATTERN];
    logic [LW-1:0]                  r_fill;
    logic [sfr_pkg::REPL_IDX_W-1:0] r_idx;
    logic [BW-1:0]                  r_pend_byte;
    logic                           r_pend_valid;
    logic                           r_out_valid;
    logic [BW-1:0]                  r_out_byte;
    logic                           r_out_pres;
    logic                           r_out_end;

    logic          cfg_we;
    logic [LW-1:0] plen;
    logic [LW-1:0] rlen;
    logic          prefix;
    logic          push;
    logic          finish;
    logic [BW-1:0] push_byte;
    logic [BW-1:0] rep_byte;
    logic          out_free;

    assign cfg_we = i_cfg_valid && i_cmd.idle;

    // lengths clamped to what the block supports
    assign plen = (r_pat_len > LW'(MAX_PATTERN)) ? LW'(MAX_PATTERN) : r_pat_len;
    assign rlen = (r_rep_len > LW'(sfr_pkg::REPL_MAX)) ? LW'(sfr_pkg::REPL_MAX) : r_rep_len;

    // held bytes against the pattern prefix
    always_comb begin
        prefix = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if ((LW'(i) < r_fill) && (r_win[i] != r_pat_bytes[i*BW +: BW])) begin
                prefix = 1'b0;
            end
        end
    end

    // byte selection for the staging register
    assign rep_byte = r_rep_bytes[{r_idx, 3'b000} +: BW];
    assign push     = (i_cmd.op == sfr_pkg::OP_PASS) || (i_cmd.op == sfr_pkg::OP_REPL)
                   || (i_cmd.op == sfr_pkg::OP_RELEASE);
    assign finish   = (i_cmd.op == sfr_pkg::OP_FINISH);

    always_comb begin
        case (i_cmd.op)
            sfr_pkg::OP_PASS: push_byte = r_in_byte;
            sfr_pkg::OP_REPL: push_byte = rep_byte;
            default:          push_byte = r_win[0];
        endcase
    end

    assign out_free = !r_out_valid || !i_out_stall;

    // status towards the controller
    assign o_status.last       = r_last;
    assign o_status.bypass     = (plen == '0) || (r_fill >= plen);
    assign o_status.prefix     = prefix;
    assign o_status.full       = (r_fill == plen);
    assign o_status.repl_empty = (rlen == '0);
    assign o_status.repl_last  = (({1'b0, r_idx} + LW'(1)) == rlen);
    assign o_status.fill_zero  = (r_fill == '0);
    assign o_status.can_push   = !r_pend_valid || out_free;
    assign o_status.finish_ok  = out_free || (!r_pend_valid && !r_last);

    // configuration, fill count, item flag and valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_bytes  <= '0;
            r_pat_len    <= '0;
            r_rep_bytes  <= '0;
            r_rep_len    <= '0;
            r_fill       <= '0;
            r_idx        <= '0;
            r_last       <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (i_cfg_index)
                    sfr_pkg::CFG_PATTERN_BYTES: begin
                        r_pat_bytes <= i_cfg_data;
                        r_fill      <= '0;
                    end
                    sfr_pkg::CFG_PATTERN_LENGTH: begin
                        r_pat_len <= i_cfg_data[LW-1:0];
                        r_fill    <= '0;
                    end
                    sfr_pkg::CFG_REPLACEMENT_BYTES: r_rep_bytes <= i_cfg_data;
                    sfr_pkg::CFG_REPLACEMENT_LENGTH: r_rep_len <= i_cfg_data[LW-1:0];
                    default: ;
                endcase
            end

            case (i_cmd.op)
                sfr_pkg::OP_LOAD:    r_last <= i_text_end;
                sfr_pkg::OP_PASS:    r_fill <= '0;
                sfr_pkg::OP_APPEND:  r_fill <= r_fill + LW'(1);
                sfr_pkg::OP_RELEASE: r_fill <= r_fill - LW'(1);
                sfr_pkg::OP_MATCH: begin
                    r_fill <= '0;
                    r_idx  <= '0;
                end
                sfr_pkg::OP_REPL:    r_idx <= r_idx + RW'(1);
                default: ;
            endcase

            // staging register feeds the output register one result behind
            if (push) begin
                r_pend_valid <= 1'b1;
            end else if (finish) begin
                r_pend_valid <= 1'b0;
            end

            if ((push && r_pend_valid) || (finish && (r_pend_valid || r_last))) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // window and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == sfr_pkg::OP_LOAD) begin
            r_in_byte <= i_text_byte;
        end

        if (i_cmd.op == sfr_pkg::OP_APPEND) begin
            for (int i = 0; i < MAX_PATTERN; i++) begin
                if (r_fill == LW'(i)) begin
                    r_win[i] <= r_in_byte;
                end
            end
        end else if (i_cmd.op == sfr_pkg::OP_RELEASE) begin
            for (int i = 0; i < MAX_PATTERN - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
        end

        if (push) begin
            r_pend_byte <= push_byte;
        end

        // an item closing with nothing to send leaves the output register alone
        if (push && r_pend_valid) begin
            r_out_byte <= r_pend_byte;
            r_out_pres <= 1'b1;
            r_out_end  <= 1'b0;
        end else if (finish && (r_pend_valid || r_last)) begin
            if (r_pend_valid) begin
                r_out_byte <= r_pend_byte;
                r_out_pres <= 1'b1;
            end else begin
                r_out_byte <= '0;
                r_out_pres <= 1'b0;
            end
            r_out_end <= r_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_byte_present = r_out_pres;
    assign o_out_end      = r_out_end;

endmodule

@@ rtl/core/stream_find_replace.sv @@
// top level of the streaming find-and-replace block
//
// Text enters one byte per item on the input channel (i_in_valid, o_in_stall),
// with i_text_end marking the final byte. Rewritten text leaves one byte per
// item on the output channel (o_out_valid, i_out_stall); o_out_end marks the
// last result of the text, and an item with o_byte_present low carries only
// that end mark. Every leftmost, non-overlapping occurrence of the pattern is
// replaced; a pattern length of zero passes bytes through.
// Registers are written through i_cfg_valid / o_cfg_ready, only taken while
// no item is in work; writing the pattern or its length empties the window.
// Each item is worked on alone by the controller: it accepts the byte, appends
// it to the window or passes it, checks the window and releases bytes, sends
// each replacement byte, at the end of text releases the window until it is
// empty, and then closes the item. Results pass through a one-deep staging
// register, so a byte leaves when the next byte of the same item or the close
// of the item moves it on. When the receiver stalls, the output register holds
// its item and the controller waits; reset empties the window and clears the
// configuration, the controller state and the valid flags.
module stream_find_replace #(
    parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [sfr_pkg::BYTE_W-1:0]     i_text_byte,
    input  logic                           i_text_end,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [sfr_pkg::BYTE_W-1:0]     o_out_byte,
    output logic                           o_byte_present,
    output logic                           o_out_end,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sfr_pkg::WORD_W-1:0]     i_cfg_data
);

    sfr_pkg::t_cmd    cmd;
    sfr_pkg::t_status status;

    // item is taken only in idle out of reset and never alongside a register write
    assign o_in_stall  = !cmd.idle || i_cfg_valid || !i_rst_n;
    assign o_cfg_ready = cmd.idle && i_rst_n;

    sfr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cfg_valid (i_cfg_valid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    sfr_datapath #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_text_byte    (i_text_byte),
        .i_text_end     (i_text_end),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_out_byte     (o_out_byte),
        .o_byte_present (o_byte_present),
        .o_out_end      (o_out_end)
    );

endmodule

@@ tb/stream_find_replace_tb.sv @@
// self-checking testbench for the streaming find-and-replace block
`timescale 1ns / 1ps

module stream_find_replace_tb;

    localparam int BYTE_W    = sfr_pkg::BYTE_W;
    localparam int WORD_W    = sfr_pkg::WORD_W;
    localparam int LEN_W     = sfr_pkg::LEN_W;
    localparam int CFG_IDX_W = sfr_pkg::CFG_IDX_W;
    localparam int REPL_MAX  = sfr_pkg::REPL_MAX;

    localparam int unsigned RESET_CYCLES     = 6;
    localparam int unsigned ITEM_TARGET      = 460;
    localparam int unsigned MAX_PAT          = sfr_pkg::MAX_PATTERN_DEF;
    localparam int unsigned MAX_STEP_RESULTS = 8;
    // settle pause covers the longest item plus the staging register
    localparam int unsigned SETTLE_CYCLES    = 40;
    localparam int unsigned LONG_HOLD_CYCLES = 300;
    localparam int unsigned PRESSURE_PHASE   = 2;
    // slowest run: ~750 items x 8 results, each with its receiver stall, sender gaps,
    // block cycles, settle pauses and the long hold, taken several times
    localparam int unsigned CYCLE_LIMIT      = 600_000;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_UNUSED  = 4'd15;

    typedef enum int {PACE_NONE, PACE_FULL, PACE_LIGHT} t_pace;

    typedef struct packed {
        logic [BYTE_W-1:0] chr;
        logic              present;
        logic              last;
    } t_out_char;

    // rewritten text expected from the block, kept in order of arrival
    class rewrite_book;
        logic [WORD_W-1:0] pattern_word;
        logic [LEN_W-1:0]  pattern_len;
        logic [WORD_W-1:0] subst_word;
        logic [LEN_W-1:0]  subst_len;
        logic [BYTE_W-1:0] window [MAX_PAT];
        int unsigned       fill;
        int unsigned       step_count;
        int unsigned       faults;
        t_out_char         awaited [$];

        function new();
            pattern_word = '0;
            pattern_len  = '0;
            subst_word   = '0;
            subst_len    = '0;
            fill         = 0;
            faults       = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] value);
            case (idx)
                sfr_pkg::CFG_PATTERN_BYTES: begin
                    pattern_word = value;
                    fill = 0;
                end
                sfr_pkg::CFG_PATTERN_LENGTH: begin
                    pattern_len = value[LEN_W-1:0];
                    fill = 0;
                end
                sfr_pkg::CFG_REPLACEMENT_BYTES:  subst_word = value;
                sfr_pkg::CFG_REPLACEMENT_LENGTH: subst_len = value[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned outstanding();
            return awaited.size();
        endfunction

        function void put_char(logic [BYTE_W-1:0] c);
            if (step_count < MAX_STEP_RESULTS) begin
                awaited.push_back('{chr: c, present: 1'b1, last: 1'b0});
                step_count++;
            end
        endfunction

        // held bytes still agree with the start of the pattern
        function bit window_on_track();
            for (int i = 0; i < fill; i++)
                if (window[i] != pattern_word[8*i +: 8])
                    return 1'b0;
            return 1'b1;
        endfunction

        function void release_oldest();
            put_char(window[0]);
            for (int i = 1; i < fill; i++)
                window[i-1] = window[i];
            fill--;
        endfunction

        function void take_text_byte(logic [BYTE_W-1:0] ch, logic is_last);
            int unsigned plen;
            int unsigned rlen;
            plen = (pattern_len > MAX_PAT) ? MAX_PAT : pattern_len;
            rlen = (subst_len > REPL_MAX) ? REPL_MAX : subst_len;
            step_count = 0;
            if (plen == 0 || fill >= plen) begin
                fill = 0;
                put_char(ch);
            end else begin
                window[fill] = ch;
                fill++;
                while (!window_on_track())
                    release_oldest();
                // whole pattern held: send the replacement instead
                if (fill == plen) begin
                    for (int i = 0; i < rlen; i++)
                        put_char(subst_word[8*i +: 8]);
                    fill = 0;
                end
            end
            // end of text: flush the window and mark the last result
            if (is_last) begin
                while (fill > 0)
                    release_oldest();
                if (step_count == 0)
                    awaited.push_back('{chr: '0, present: 1'b0, last: 1'b1});
                else
                    awaited[awaited.size()-1].last = 1'b1;
            end
        endfunction

        function void check_out_byte(logic [BYTE_W-1:0] c, logic p, logic e);
            t_out_char want;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result, byte %02h present %0b end %0b",
                         $time, c, p, e);
                faults++;
                return;
            end
            want = awaited.pop_front();
            if (want.chr !== c) begin
                $display("%0t: out_byte expected %02h got %02h", $time, want.chr, c);
                faults++;
            end
            if (want.present !== p) begin
                $display("%0t: byte_present expected %0b got %0b", $time, want.present, p);
                faults++;
            end
            if (want.last !== e) begin
                $display("%0t: out_end expected %0b got %0b", $time, want.last, e);
                faults++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [BYTE_W-1:0]    i_text_byte;
    logic                 i_text_end;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [BYTE_W-1:0]    o_out_byte;
    logic                 o_byte_present;
    logic                 o_out_end;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [WORD_W-1:0]    i_cfg_data;

    rewrite_book book;
    t_pace       pace = PACE_FULL;
    int unsigned hold_left = 0;
    int unsigned bytes_sent = 0;
    int unsigned cycle_count = 0;
    bit          pressure_go = 1'b0;
    bit          long_hold = 1'b0;

    stream_find_replace DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_text_byte    (i_text_byte),
        .i_text_end     (i_text_end),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_byte_present (o_byte_present),
        .o_out_end      (o_out_end),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // wait drawn per item, shared by sender and receiver
    function automatic int unsigned pause_draw();
        case (pace)
            PACE_NONE: return 0;
            PACE_FULL: return $urandom_range(0, 15);
            default:   return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0;
        endcase
    endfunction

    // receiver stall, drawn per item plus the one long hold-off
    initial begin : receiver
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_stall <= long_hold || (hold_left != 0);
            if (hold_left != 0)
                hold_left--;
        end
    end

    // long hold-off, counted on its own
    initial begin : hold_off
        wait (pressure_go);
        @(posedge i_clk);
        long_hold = 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
        long_hold = 1'b0;
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            book.check_out_byte(o_out_byte, o_byte_present, o_out_end);
            hold_left = pause_draw();
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // offer one text item and wait for it to be taken
    task automatic offer_text_byte(input logic [BYTE_W-1:0] ch, input logic is_last);
        int unsigned gap;
        gap = pause_draw();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_text_byte <= ch;
        i_text_end  <= is_last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        book.take_text_byte(ch, is_last);
        bytes_sent++;
    endtask

    task automatic offer_text(input string s, input bit closes);
        for (int i = 0; i < s.len(); i++)
            offer_text_byte(s[i], closes && (i == s.len() - 1));
    endtask

    // let every expected item out and the block go idle
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (book.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [WORD_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        book.write_register(idx, value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [BYTE_W-1:0] letters [3];
        logic [BYTE_W-1:0] text_q [$];
        logic [WORD_W-1:0] pat_word;
        logic [WORD_W-1:0] pat_len_word;
        logic [WORD_W-1:0] rep_len_word;
        int unsigned       len_code;
        int unsigned       eff;
        int unsigned       pick;
        int unsigned       n;
        int unsigned       cut;

        book        = new();
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_text_byte = '0;
        i_text_end  = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration passes bytes through
        offer_text_byte(8'h00, 1'b0);
        offer_text_byte(8'hFF, 1'b1);
        settle();

        // mismatch shifts the window, then a full match, then an end flush
        write_register(sfr_pkg::CFG_PATTERN_BYTES, 64'h0000_0000_0062_6161);
        write_register(sfr_pkg::CFG_PATTERN_LENGTH, 64'd3);
        write_register(sfr_pkg::CFG_REPLACEMENT_BYTES, 64'h0000_0000_005A_5958);
        write_register(sfr_pkg::CFG_REPLACEMENT_LENGTH, 64'd3);
        offer_text("aaab", 1'b1);
        offer_text("aa", 1'b1);
        settle();

        // empty replacement: a text that is only the pattern gives the end mark alone
        write_register(sfr_pkg::CFG_REPLACEMENT_LENGTH, 64'd0);
        offer_text("aab", 1'b1);

        // pattern rewritten while the window holds bytes
        offer_text("aa", 1'b0);
        settle();
        write_register(sfr_pkg::CFG_PATTERN_LENGTH, 64'd2);
        offer_text("ab", 1'b1);
        settle();

        // lengths above range clamp to eight
        write_register(sfr_pkg::CFG_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
        write_register(sfr_pkg::CFG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF);
        write_register(sfr_pkg::CFG_REPLACEMENT_BYTES, 64'h8001_7FFE_00FF_55AA);
        write_register(sfr_pkg::CFG_REPLACEMENT_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF);
        for (int i = 0; i < 8; i++)
            offer_text_byte(8'hFF, i == 7);
        settle();

        // reserved index changes nothing
        write_register(CFG_LAST_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
        offer_text_byte(8'hFF, 1'b1);
        settle();

        // random phases: new settings, then texts built around the pattern
        for (int phase = 0; bytes_sent < ITEM_TARGET; phase++) begin
            pace = t_pace'($urandom_range(0, 2));
            letters[0] = BYTE_W'($urandom_range(0, 255));
            letters[1] = BYTE_W'($urandom_range(0, 255));
            letters[2] = BYTE_W'($urandom_range(0, 255));
            if ($urandom_range(0, 3) == 0) begin
                letters[1] = letters[0];
                letters[2] = letters[0];
            end
            pick = $urandom_range(0, 9);
            len_code = (pick == 0) ? 0 : (pick == 1) ? 8 :
                       (pick == 2) ? $urandom_range(9, 15) : $urandom_range(1, 7);
            eff = (len_code > MAX_PAT) ? MAX_PAT : len_code;
            pat_word = {$urandom, $urandom};
            for (int k = 0; k < eff; k++)
                pat_word[8*k +: 8] = letters[$urandom_range(0, 2)];
            pat_len_word = {$urandom, $urandom};
            if ($urandom_range(0, 1) == 0)
                pat_len_word[WORD_W-1:LEN_W] = '0;
            pat_len_word[LEN_W-1:0] = LEN_W'(len_code);
            pick = $urandom_range(0, 9);
            rep_len_word = {$urandom, $urandom};
            if ($urandom_range(0, 1) == 0)
                rep_len_word[WORD_W-1:LEN_W] = '0;
            rep_len_word[LEN_W-1:0] = LEN_W'((pick == 0) ? 0 : (pick == 1) ? 8 :
                                      (pick == 2) ? $urandom_range(9, 15) : $urandom_range(1, 7));

            write_register(sfr_pkg::CFG_PATTERN_BYTES, pat_word);
            write_register(sfr_pkg::CFG_PATTERN_LENGTH, pat_len_word);
            write_register(sfr_pkg::CFG_REPLACEMENT_BYTES, {$urandom, $urandom});
            write_register(sfr_pkg::CFG_REPLACEMENT_LENGTH, rep_len_word);
            if ($urandom_range(0, 3) == 0)
                write_register(CFG_IDX_W'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_UNUSED)),
                               {$urandom, $urandom});

            // sender keeps offering while the receiver holds off
            if (phase == PRESSURE_PHASE) begin
                pace = PACE_NONE;
                pressure_go = 1'b1;
            end

            repeat ($urandom_range(2, 6)) begin
                text_q.delete();
                repeat ($urandom_range(1, 6)) begin
                    pick = $urandom_range(0, 9);
                    if (pick < 4 && eff > 0) begin
                        for (int k = 0; k < eff; k++)
                            text_q.push_back(pat_word[8*k +: 8]);
                    end else if (pick < 6 && eff > 1) begin
                        n = $urandom_range(1, eff - 1);
                        for (int k = 0; k < n; k++)
                            text_q.push_back(pat_word[8*k +: 8]);
                    end else if (pick < 8) begin
                        text_q.push_back(letters[$urandom_range(0, 2)]);
                    end else begin
                        text_q.push_back(BYTE_W'($urandom_range(0, 255)));
                    end
                end
                // now and then the pattern is rewritten part way through a text
                cut = text_q.size();
                if (text_q.size() > 1 && $urandom_range(0, 7) == 0)
                    cut = $urandom_range(1, text_q.size() - 1);
                for (int i = 0; i < text_q.size(); i++) begin
                    if (i == cut) begin
                        settle();
                        if ($urandom_range(0, 1) == 0)
                            write_register(sfr_pkg::CFG_PATTERN_LENGTH, pat_len_word);
                        else
                            write_register(sfr_pkg::CFG_PATTERN_BYTES, pat_word);
                    end
                    offer_text_byte(text_q[i], i == text_q.size() - 1);
                end
            end
            settle();
        end

        if (book.faults == 0 && book.outstanding() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
